@@ hdl/mhi_pkg.sv @@
package mhi_pkg;

  // table geometry
  localparam int LEVELS    = 10;
  localparam int HASH_WAYS = 3;
  localparam int NUM_HASH  = 3;
  localparam int KEY_W     = 64;
  localparam int ADDR_W    = LEVELS;
  localparam int HASH_W    = LEVELS - 1;
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int WAY_W     = 2;

  // result field widths
  localparam int STATUS_W      = 2;
  localparam int FOUND_LEVEL_W = 4;
  localparam int FOUND_SLOT_W  = 9;
  localparam int HASH_WAY_W    = 2;

  typedef logic [FOUND_LEVEL_W-1:0] found_level_t;
  typedef logic [FOUND_SLOT_W-1:0]  found_slot_t;
  typedef logic [HASH_WAY_W-1:0]    hash_way_t;

  // configuration port
  localparam int DATA_W  = 64;
  localparam int PADDR_W = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MULT_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ADD_0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MULT_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ADD_1  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MULT_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ADD_2  = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_PRESENT  = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

  // slot mask of a level: ones below bit lvl
  function automatic logic [HASH_W-1:0] slot_mask(input logic [LVL_W-1:0] lvl);
    logic [HASH_W-1:0] m;
    for (int i = 0; i < HASH_W; i++) begin
      m[i] = (i < int'(lvl));
    end
    return m;
  endfunction

  // flat address of the first slot of a level, 2^lvl - 1
  function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
    logic [ADDR_W-1:0] b;
    for (int i = 0; i < ADDR_W; i++) begin
      b[i] = (i < int'(lvl));
    end
    return b;
  endfunction

endpackage

@@ hdl/multilevel_hash_insert.sv @@
// Each key is hashed, then probed with P probes (1 to 3 per level in use), each a memory
//   read then a compare, with one more step when a new level is opened or the table is full.
// A new key is taken only in IDLE, once the previous result is loaded into the outputs.
// The three hashes come from one shared multiplier, one way per cycle.
// Reset: synchronous; a clearing pass then walks the slot memory, one entry a cycle,
//   during which no key is taken; configuration writes are taken throughout.
module multilevel_hash_insert (
  input  logic                                  clk,
  input  logic                                  rst,
  // key input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mhi_pkg::KEY_W-1:0]             key_value,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mhi_pkg::STATUS_W-1:0]          status,
  output logic [mhi_pkg::FOUND_LEVEL_W-1:0]     found_level,
  output logic [mhi_pkg::FOUND_SLOT_W-1:0]      found_slot,
  output logic [mhi_pkg::HASH_WAY_W-1:0]        hash_way,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mhi_pkg::PADDR_W-1:0]           paddr,
  input  logic [mhi_pkg::DATA_W-1:0]            pwdata,
  output logic [mhi_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    HASH,
    PROBE_RD,
    PROBE_CMP,
    OPEN,
    FINISH
  } state_t;

  localparam int DEPTH = 1 << mhi_pkg::ADDR_W;

  state_t state;

  logic [mhi_pkg::DATA_W-1:0] hash_mult [mhi_pkg::NUM_HASH];
  logic [mhi_pkg::DATA_W-1:0] hash_add  [mhi_pkg::NUM_HASH];

  logic [mhi_pkg::KEY_W-1:0]  key;
  logic [mhi_pkg::HASH_W-1:0] hash [mhi_pkg::NUM_HASH];
  logic [mhi_pkg::WAY_W-1:0]  way;
  logic [mhi_pkg::LVL_W-1:0]  lvl;
  logic [mhi_pkg::LVL_W-1:0]  levels_used;
  logic [mhi_pkg::ADDR_W-1:0] clr_addr;
  logic [mhi_pkg::ADDR_W-1:0] probe_addr;
  logic [mhi_pkg::HASH_W-1:0] probe_slot;

  // pending result
  mhi_pkg::status_t           res_status;
  logic [mhi_pkg::LVL_W-1:0]  res_level;
  logic [mhi_pkg::HASH_W-1:0] res_slot;
  logic [mhi_pkg::WAY_W-1:0]  res_way;

  // slot memory: used flag above the stored key
  logic [mhi_pkg::KEY_W:0]    mem [DEPTH];
  logic [mhi_pkg::KEY_W:0]    rd_data;
  logic                       mem_wr_en;
  logic [mhi_pkg::ADDR_W-1:0] mem_wr_addr;
  logic [mhi_pkg::KEY_W:0]    mem_wr_data;

  logic                       cfg_write;
  logic [mhi_pkg::REG_IDX_W-1:0] cfg_idx;

  logic [mhi_pkg::HASH_W-1:0] hash_prod;
  logic [mhi_pkg::HASH_W-1:0] hash_next;
  logic [mhi_pkg::HASH_W-1:0] cur_slot;
  logic [mhi_pkg::ADDR_W-1:0] cur_addr;
  logic [mhi_pkg::HASH_W-1:0] open_slot;
  logic [mhi_pkg::ADDR_W-1:0] open_addr;
  logic                       can_open;
  logic                       rd_used;
  logic                       rd_match;
  logic                       last_way;
  logic                       last_level;

  assign in_stall = (state != IDLE);
  assign pready   = 1'b1;

  // configuration decode
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[mhi_pkg::PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mhi_pkg::NUM_HASH; i++) begin
        hash_mult[i] <= mhi_pkg::DATA_W'(1);
        hash_add[i]  <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_idx)
        mhi_pkg::REG_MULT_0: hash_mult[0] <= pwdata;
        mhi_pkg::REG_ADD_0:  hash_add[0]  <= pwdata;
        mhi_pkg::REG_MULT_1: hash_mult[1] <= pwdata;
        mhi_pkg::REG_ADD_1:  hash_add[1]  <= pwdata;
        mhi_pkg::REG_MULT_2: hash_mult[2] <= pwdata;
        mhi_pkg::REG_ADD_2:  hash_add[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      mhi_pkg::REG_MULT_0: prdata = hash_mult[0];
      mhi_pkg::REG_ADD_0:  prdata = hash_add[0];
      mhi_pkg::REG_MULT_1: prdata = hash_mult[1];
      mhi_pkg::REG_ADD_1:  prdata = hash_add[1];
      mhi_pkg::REG_MULT_2: prdata = hash_mult[2];
      mhi_pkg::REG_ADD_2:  prdata = hash_add[2];
      default:             prdata = '0;
    endcase
  end

  // shared hash unit: only the low slot bits of the product are ever needed
  assign hash_prod = mhi_pkg::HASH_W'(hash_mult[way][mhi_pkg::HASH_W-1:0] *
                                      key[mhi_pkg::HASH_W-1:0]);
  assign hash_next = hash_prod + hash_add[way][mhi_pkg::HASH_W-1:0];

  // probe and open addresses
  assign cur_slot  = hash[way] & mhi_pkg::slot_mask(lvl);
  assign cur_addr  = mhi_pkg::level_base(lvl) + mhi_pkg::ADDR_W'(cur_slot);
  assign open_slot = hash[0] & mhi_pkg::slot_mask(levels_used);
  assign open_addr = mhi_pkg::level_base(levels_used) + mhi_pkg::ADDR_W'(open_slot);
  assign can_open  = (levels_used < mhi_pkg::LVL_W'(mhi_pkg::LEVELS));

  assign rd_used    = rd_data[mhi_pkg::KEY_W];
  assign rd_match   = (rd_data[mhi_pkg::KEY_W-1:0] == key);
  assign last_way   = (way == mhi_pkg::WAY_W'(mhi_pkg::HASH_WAYS - 1));
  assign last_level = (lvl == levels_used - 1'b1);

  // memory write selection
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = probe_addr;
    mem_wr_data = {1'b1, key};
    case (state)
      CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      PROBE_CMP: begin
        mem_wr_en = !rd_used;
      end
      OPEN: begin
        mem_wr_en   = can_open;
        mem_wr_addr = open_addr;
      end
      default: ;
    endcase
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (state == PROBE_RD) begin
      rd_data <= mem[cur_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      clr_addr    <= '0;
      levels_used <= mhi_pkg::LVL_W'(1);
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == mhi_pkg::ADDR_W'(DEPTH - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            key   <= key_value;
            way   <= '0;
            state <= HASH;
          end
        end
        HASH: begin
          hash[way] <= hash_next;
          if (last_way) begin
            way   <= '0;
            lvl   <= '0;
            state <= PROBE_RD;
          end else begin
            way <= way + 1'b1;
          end
        end
        PROBE_RD: begin
          probe_addr <= cur_addr;
          probe_slot <= cur_slot;
          state      <= PROBE_CMP;
        end
        PROBE_CMP: begin
          if (!rd_used || rd_match) begin
            res_status <= rd_used ? mhi_pkg::STATUS_PRESENT : mhi_pkg::STATUS_INSERTED;
            res_level  <= lvl;
            res_slot   <= probe_slot;
            res_way    <= way;
            state      <= FINISH;
          end else if (last_way) begin
            way <= '0;
            if (last_level) begin
              state <= OPEN;
            end else begin
              lvl   <= lvl + 1'b1;
              state <= PROBE_RD;
            end
          end else begin
            way   <= way + 1'b1;
            state <= PROBE_RD;
          end
        end
        OPEN: begin
          res_way <= '0;
          if (can_open) begin
            levels_used <= levels_used + 1'b1;
            res_status  <= mhi_pkg::STATUS_INSERTED;
            res_level   <= levels_used;
            res_slot    <= open_slot;
          end else begin
            res_status <= mhi_pkg::STATUS_FULL;
            res_level  <= '0;
            res_slot   <= '0;
          end
          state <= FINISH;
        end
        FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found_level <= mhi_pkg::found_level_t'(res_level);
            found_slot  <= mhi_pkg::found_slot_t'(res_slot);
            hash_way    <= mhi_pkg::hash_way_t'(res_way);
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // level count stays within the stack
  a_levels_range: assert property (@(posedge clk) disable iff (rst)
    levels_used >= mhi_pkg::LVL_W'(1) && levels_used <= mhi_pkg::LVL_W'(mhi_pkg::LEVELS))
    else $error("levels in use out of range");

  // slot memory written only by the clearing pass or a deciding step
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (state == CLEAR || state == PROBE_CMP || state == OPEN))
    else $error("slot memory written outside a deciding state");

  // a new result appears only from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == FINISH)
    else $error("result raised outside finish");

  // a full table reports no position
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mhi_pkg::STATUS_FULL) |->
      (found_level == '0 && found_slot == '0 && hash_way == '0))
    else $error("table full result carries a position");

  // opening a level grows the count by one
  a_open_step: assert property (@(posedge clk) disable iff (rst)
    (state == OPEN && can_open) |=> levels_used == $past(levels_used) + 1'b1)
    else $error("level count did not advance on open");

endmodule
